/* hw/rtl/cer_pkg.sv */
// cer_pkg: shared constants, register indexes and types for comb_echo_reverb.
// No dependencies; every other file of the block refers to it by scoped names.
package cer_pkg;

    localparam int MEM_DEPTH   = 65536;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int SAMPLE_W    = 16;
    localparam int OFFSET_W    = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_LAST     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERB_LAST   = 2'd2;

    localparam logic [OFFSET_W-1:0] LAST_OFFSET_RESET  = 16'd4095;

    typedef enum logic {
        MODE_ECHO   = 1'b0,
        MODE_REVERB = 1'b1
    } cer_mode_t;

    // Active settings handed from the register file to the datapath
    typedef struct packed {
        cer_mode_t         mode;
        logic [ADDR_W-1:0] last;
    } cer_cfg_t;

endpackage

/* hw/rtl/comb_echo_reverb.sv */
// comb_echo_reverb: echo / reverb comb filter on unsigned 16-bit samples.
// Depends on cer_pkg, cer_cfg_regs, cer_ring_pos and cer_delay_mem.
//
// Usage:
//   Input requests arrive on s_valid / s_ready with s_in_sample; each one
//   produces exactly one result request on m_valid / m_ready with
//   m_out_sample = floor((2*in + delayed) / 4), delayed being the memory entry
//   at the current ring position. Echo mode stores the input back into that
//   entry, reverb mode stores the output.
//   An accepted request waits in the read stage, then moves to the output register.
//   Throughput: one sample per cycle while the output is not stalled, set by the
//   single read-modify-write of one memory entry per sample (read on accept, write
//   on leaving the read stage); a same-entry read in the write cycle is forwarded.
//   Configuration: cfg_we / cfg_addr / cfg_wdata write a register
//   (0 effect mode, 1 echo last offset, 2 reverb last offset); write
//   only while no sample is in flight. The delay is last offset plus one.
//   Reset (aresetn low, synchronous): position returns to 0, registers to
//   echo mode with last offsets of 4095, and the delay memory reads as all
//   zeros through a fill count; no clearing pass, s_ready is high at once.
//   Receiver stall: the output register holds its result; one more sample
//   may be accepted into the read stage, after which s_ready drops until
//   the result is taken.
module comb_echo_reverb (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [cer_pkg::SAMPLE_W-1:0]   s_in_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cer_pkg::SAMPLE_W-1:0]   m_out_sample,
    input  logic                           cfg_we,
    input  logic [cer_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [cer_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    cer_pkg::cer_cfg_t              cfg;
    logic [cer_pkg::ADDR_W-1:0]     pos;
    logic                           accept;

    // Read stage: sample waits here for its memory read data
    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic [cer_pkg::SAMPLE_W-1:0]   s1_x_reg;
    logic [cer_pkg::ADDR_W-1:0]     s1_addr_reg;
    logic                           s1_adv;
    logic [cer_pkg::SAMPLE_W-1:0]   delayed;
    logic [cer_pkg::SAMPLE_W+1:0]   mix_sum;
    logic [cer_pkg::SAMPLE_W-1:0]   mix_out;
    logic [cer_pkg::SAMPLE_W-1:0]   wb_data;

    // Output register
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [cer_pkg::SAMPLE_W-1:0]   out_sample_reg;

    cer_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Position depends only on itself, the settings and accept: advance on accept
    cer_ring_pos u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (accept),
        .cfg     (cfg),
        .pos     (pos)
    );

    cer_delay_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (pos),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (wb_data),
        .rd_data (delayed)
    );

    // Output slot frees when empty or being taken; the read stage moves into it
    assign s1_adv  = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;

    always_comb begin
        mix_sum = {1'b0, s1_x_reg, 1'b0} + {2'b00, delayed};
        mix_out = mix_sum[cer_pkg::SAMPLE_W+1:2];
        wb_data = (cfg.mode == cer_pkg::MODE_REVERB) ? mix_out : s1_x_reg;

        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on the stage handshakes, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_x_reg    <= s_in_sample;
            s1_addr_reg <= pos;
        end
        if (s1_adv) begin
            out_sample_reg <= mix_out;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_sample = out_sample_reg;

    // Input stalls only behind a full read stage facing a stalled output
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid && !m_ready))
        else $error("s_ready low without a downstream stall");

    // A read-stage sample with room ahead reaches the output next cycle
    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && (!m_valid || m_ready)) |=> m_valid)
        else $error("read stage sample lost");

    // Mix of x/2 and d/4 stays within three quarters of full scale
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_sample <= 16'd49151))
        else $error("output sample out of range");

endmodule

/* hw/rtl/cer_cfg_regs.sv */
// cer_cfg_regs: configuration registers and last-offset clamp for comb_echo_reverb.
// Depends on cer_pkg.
module cer_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [cer_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [cer_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output cer_pkg::cer_cfg_t             cfg
);

    cer_pkg::cer_mode_t               mode_reg;
    logic [cer_pkg::OFFSET_W-1:0]     echo_last_reg;
    logic [cer_pkg::OFFSET_W-1:0]     reverb_last_reg;
    logic [cer_pkg::OFFSET_W-1:0]     sel_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= cer_pkg::MODE_ECHO;
            echo_last_reg   <= cer_pkg::LAST_OFFSET_RESET;
            reverb_last_reg <= cer_pkg::LAST_OFFSET_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                cer_pkg::REG_EFFECT_MODE: begin
                    mode_reg <= cer_pkg::cer_mode_t'(cfg_wdata[0]);
                end
                cer_pkg::REG_ECHO_LAST: begin
                    echo_last_reg <= cfg_wdata[cer_pkg::OFFSET_W-1:0];
                end
                cer_pkg::REG_REVERB_LAST: begin
                    reverb_last_reg <= cfg_wdata[cer_pkg::OFFSET_W-1:0];
                end
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    always_comb begin
        sel_last = (mode_reg == cer_pkg::MODE_REVERB) ? reverb_last_reg : echo_last_reg;
        cfg.mode = mode_reg;
        // saturate at the top of the delay memory
        if (32'(sel_last) > 32'(cer_pkg::MEM_DEPTH - 1)) begin
            cfg.last = cer_pkg::ADDR_W'(cer_pkg::MEM_DEPTH - 1);
        end else begin
            cfg.last = cer_pkg::ADDR_W'(sel_last);
        end
    end

endmodule

/* hw/rtl/cer_ring_pos.sv */
// cer_ring_pos: ring position counter with wrap at the active last offset.
// Depends on cer_pkg.
module cer_ring_pos (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  cer_pkg::cer_cfg_t          cfg,
    output logic [cer_pkg::ADDR_W-1:0] pos
);

    logic [cer_pkg::ADDR_W-1:0] pos_reg;
    logic [cer_pkg::ADDR_W-1:0] pos_next;
    logic [cer_pkg::ADDR_W:0]   pos_inc;

    always_comb begin
        pos_inc  = {1'b0, pos_reg} + {{cer_pkg::ADDR_W{1'b0}}, 1'b1};
        pos_next = pos_reg;
        if (advance) begin
            if (pos_inc > {1'b0, cfg.last}) begin
                pos_next = '0;
            end else begin
                pos_next = pos_inc[cer_pkg::ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

/* hw/rtl/cer_delay_mem.sv */
// cer_delay_mem: delay sample memory, one read and one write port, registered read.
// Adds write-to-read forwarding and a fill count that makes unwritten entries read zero.
// Depends on cer_pkg.
module cer_delay_mem (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [cer_pkg::ADDR_W-1:0]   rd_addr,
    input  logic                         wr_en,
    input  logic [cer_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [cer_pkg::SAMPLE_W-1:0] wr_data,
    output logic [cer_pkg::SAMPLE_W-1:0] rd_data
);

    logic [cer_pkg::SAMPLE_W-1:0] mem [cer_pkg::MEM_DEPTH];
    logic [cer_pkg::SAMPLE_W-1:0] rd_q_reg;
    logic [cer_pkg::SAMPLE_W-1:0] fwd_data_reg;
    logic                         fwd_hit_reg;
    logic                         blank_reg;
    // Entries below fill_reg have been written since reset; the ring fills in order
    logic [cer_pkg::ADDR_W:0]     fill_reg;
    logic [cer_pkg::ADDR_W:0]     fill_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg     <= mem[rd_addr];
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
            blank_reg    <= ({1'b0, rd_addr} >= fill_reg);
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (wr_en && ({1'b0, wr_addr} == fill_reg)) begin
            fill_next = fill_reg + {{cer_pkg::ADDR_W{1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_comb begin
        if (fwd_hit_reg) begin
            rd_data = fwd_data_reg;
        end else if (blank_reg) begin
            rd_data = '0;
        end else begin
            rd_data = rd_q_reg;
        end
    end

endmodule
